FILE: rtl/wzht_pkg.sv
// ----------------------------------------------------------------------------
// wzht_pkg: shared types and constants for the window z-order hit test unit
// Entry layout, operation and status codes, cell control struct.
// ----------------------------------------------------------------------------
package wzht_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W = $clog2(MAX_WINDOWS);
  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_MOVE   = 3'd2,
    OP_RESIZE = 3'd3,
    OP_CLOSE  = 3'd4,
    OP_OPEN   = 3'd5,
    OP_CLICK  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic shift_dn;  // cells at or above lo take the upper neighbor
    logic shift_up;  // cells at or below hi (and above 0) take the lower neighbor
    logic load;      // cell at load_idx takes load_data
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] load_idx;
  } cell_ctl_t;

endpackage

FILE: rtl/wzht_cell.sv
// ----------------------------------------------------------------------------
// wzht_cell: one stack slot
// Holds one rectangle; shifts to or from a neighbor or loads a new entry.
// ----------------------------------------------------------------------------
module wzht_cell (
  input  logic                    clk,
  input  logic [wzht_pkg::IDX_W-1:0] my_idx,
  input  wzht_pkg::cell_ctl_t     ctl,
  input  wzht_pkg::entry_t        load_data,
  input  wzht_pkg::entry_t        from_above,
  input  wzht_pkg::entry_t        from_below,
  output wzht_pkg::entry_t        entry
);
  import wzht_pkg::*;

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load && ctl.load_idx == my_idx) begin
      entry_nxt = load_data;
    end else if (ctl.shift_dn && my_idx >= ctl.lo) begin
      entry_nxt = from_above;
    end else if (ctl.shift_up && my_idx <= ctl.hi && my_idx != '0) begin
      entry_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
endmodule

FILE: rtl/window_z_order_hit_test_unit.sv
// ----------------------------------------------------------------------------
// window_z_order_hit_test_unit: z-ordered rectangle stack with hit test
// Usage:
//  - in_*: one request per transfer. tdata holds, from bit 0 up:
//    operation(3) window_id(16) coord_x(16) coord_y(16) size_w(15) size_h(15),
//    zero padded to 88 bits.
//  - out_*: one result per request. tdata holds status(2) result_id(16),
//    zero padded to 24 bits.
//  - The stack lives in a row of cells, index 0 the bottom. A request scans
//    the row one entry per cycle through a scan pointer (search from bottom
//    for an id, from top for a click), then updates the row with a broadcast
//    shift from the hit (up or down), a write of the picked or new entry, or both.
//  - Create and none skip the scan; others stop it at the first match or once
//    every entry is passed over (id not found). One request at a time: the
//    next input transfer is taken only once the result is loaded.
//  - The result sits in an output register; a new request is taken as soon as
//    the result is loaded there and the register is free or being drained.
//  - Reset (synchronous, rst_n low) empties the stack and zeros the id
//    counter; cell contents are left undefined and never read.
//  - A stalled out_tready just holds the result; nothing is lost.
// ----------------------------------------------------------------------------
module window_z_order_hit_test_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // operation, window_id, coord_x, coord_y, size_w, size_h
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status, result_id
);
  import wzht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_APPLY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [15:0] id_r, cx_r, cy_r;
  logic [14:0] sw_r, sh_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;  // entries still to scan
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic found_r, found_nxt;
  entry_t hit_e_r, hit_e_nxt;
  status_t st_r, st_nxt;
  logic [15:0] rid_r, rid_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [1:0] ost_r;
  logic [15:0] orid_r;

  entry_t cells [MAX_WINDOWS];
  cell_ctl_t ctl;
  entry_t load_data;
  entry_t cur;
  logic match;
  logic in_fire, out_free;
  logic signed [16:0] rx0, rx1, ry0, ry1, px, py;
  logic [IDX_W-1:0] top_idx;

  genvar g;
  generate
    for (g = 0; g < MAX_WINDOWS; g++) begin : g_cell
      wzht_cell u_cell (
        .clk       (clk),
        .my_idx    (IDX_W'(g)),
        .ctl       (ctl),
        .load_data (load_data),
        .from_above(cells[(g + 1) % MAX_WINDOWS]),
        .from_below(cells[(g + MAX_WINDOWS - 1) % MAX_WINDOWS]),
        .entry     (cells[g])
      );
    end
  endgenerate

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign top_idx   = IDX_W'(count_r - CNT_W'(1));

  // Scanned entry and its match: hit test for a click, id compare otherwise.
  assign cur = cells[ptr_r];
  assign rx0 = {cur.x[15], cur.x};
  assign ry0 = {cur.y[15], cur.y};
  assign rx1 = rx0 + $signed({2'b00, cur.w});
  assign ry1 = ry0 + $signed({2'b00, cur.h});
  assign px  = {cx_r[15], cx_r};
  assign py  = {cy_r[15], cy_r};
  always_comb begin
    if (op_r == OP_CLICK) begin
      match = (px >= rx0) && (px < rx1) && (py >= ry0) && (py < ry1);
    end else begin
      match = (cur.id == id_r);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    ptr_nxt     = ptr_r;
    left_nxt    = left_r;
    hit_nxt     = hit_r;
    found_nxt   = found_r;
    hit_e_nxt   = hit_e_r;
    st_nxt      = st_r;
    rid_nxt     = rid_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ctl         = '0;
    load_data   = hit_e_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          found_nxt = 1'b0;
          left_nxt  = count_r;
          if (op_t'(in_tdata[2:0]) == OP_CLICK) begin
            ptr_nxt = top_idx;
          end else begin
            ptr_nxt = '0;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (op_r == OP_CREATE || op_r == OP_NONE) begin
          state_nxt = S_APPLY;
        end else if (left_r == '0) begin
          state_nxt = S_APPLY;
        end else if (match) begin
          found_nxt = 1'b1;
          hit_nxt   = ptr_r;
          hit_e_nxt = cur;
          state_nxt = S_APPLY;
        end else begin
          left_nxt = left_r - CNT_W'(1);
          ptr_nxt  = (op_r == OP_CLICK) ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
        end
      end
      S_APPLY: begin
        st_nxt  = ST_OK;
        rid_nxt = '0;
        ctl.lo  = hit_r;
        ctl.hi  = hit_r;
        ctl.load_idx = top_idx;
        case (op_r)
          OP_CREATE: begin
            if (count_r == CNT_W'(MAX_WINDOWS)) begin
              st_nxt = ST_FULL;
            end else begin
              ctl.load     = 1'b1;
              ctl.load_idx = IDX_W'(count_r);
              load_data    = '{id: next_id_r, x: cx_r, y: cy_r, w: sw_r, h: sh_r};
              count_nxt    = count_r + CNT_W'(1);
              rid_nxt      = next_id_r;
              next_id_nxt  = next_id_r + 16'd1;
            end
          end
          OP_CLICK: begin
            if (!found_r) begin
              st_nxt = ST_MISS;
            end else begin
              rid_nxt      = hit_e_r.id;
              ctl.shift_dn = 1'b1;
              ctl.load     = 1'b1;
            end
          end
          OP_NONE: ;
          default: begin
            if (!found_r) begin
              st_nxt = ST_UNKNOWN;
            end else if (op_r == OP_DELETE) begin
              ctl.shift_dn = 1'b1;
              count_nxt    = count_r - CNT_W'(1);
            end else if (op_r == OP_CLOSE) begin
              ctl.shift_up = 1'b1;
              ctl.load     = 1'b1;
              ctl.load_idx = '0;
            end else begin
              ctl.shift_dn = 1'b1;
              ctl.load     = 1'b1;
              if (op_r == OP_MOVE) begin
                load_data.x = hit_e_r.x + cx_r;
                load_data.y = hit_e_r.y + cy_r;
              end else if (op_r == OP_RESIZE) begin
                load_data.w = sw_r;
                load_data.h = sh_r;
              end
            end
          end
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      next_id_r <= '0;
      ovalid_r  <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      ovalid_r  <= ovalid_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_t'(in_tdata[2:0]);
      id_r <= in_tdata[18:3];
      cx_r <= in_tdata[34:19];
      cy_r <= in_tdata[50:35];
      sw_r <= in_tdata[65:51];
      sh_r <= in_tdata[80:66];
    end
    ptr_r   <= ptr_nxt;
    left_r  <= left_nxt;
    hit_r   <= hit_nxt;
    hit_e_r <= hit_e_nxt;
    st_r    <= st_nxt;
    rid_r   <= rid_nxt;
    if (state_r == S_DONE && out_free) begin
      ost_r  <= st_r;
      orid_r <= rid_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, orid_r, ost_r};

  // Stack never exceeds its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WINDOWS)) else $error("stack count over depth");
  // Stall holds the result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // Count changes only in the apply step.
  a_count_apply: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_nxt |-> state_r == S_APPLY) else $error("count moved outside apply");
  // Non-ok status never carries an id.
  a_rid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[17:2] == 16'd0)
    else $error("id with error status");
endmodule
